/* rtl/pfg_pkg.sv */
`default_nettype none

package pfg_pkg;

  // Frame shape
  localparam int FRAME_TICKS  = 1000;
  localparam int GAP_TICKS    = 25;
  localparam int NUM_CHANNELS = 8;

  // Field and boundary widths
  localparam int CNT_W   = 10;
  localparam int IDX_W   = 3;
  localparam int WIDTH_W = 8;
  localparam int BOUND_W = 12;

  // Reset widths
  localparam int RESET_WIDTH    = 75;
  localparam int RESET_THROTTLE = 50;
  localparam int THROTTLE_SLOT  = 2;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef logic [BOUND_W-1:0] bound_t;
  typedef logic [NUM_CHANNELS-1:0][BOUND_W-1:0] bound_vec_t;

  // Width update request into the bound bank
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   index;
    logic [WIDTH_W-1:0] value;
  } width_wr_t;

  function automatic logic [WIDTH_W-1:0] reset_width(input int k);
    if (k == THROTTLE_SLOT) begin
      return WIDTH_W'(RESET_THROTTLE);
    end
    return WIDTH_W'(RESET_WIDTH);
  endfunction

  // End of channel k's high span at reset: gaps so far plus widths so far
  function automatic bound_t reset_bound(input int k);
    int s;
    s = GAP_TICKS * (k + 1);
    for (int j = 0; j <= k; j++) begin
      s = s + int'(reset_width(j));
    end
    return BOUND_W'(s);
  endfunction

endpackage

`default_nettype wire

/* rtl/pfg_bound_bank.sv */
`default_nettype none

module pfg_bound_bank
  import pfg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire width_wr_t  wr,
  output bound_vec_t      hi_bound
);

  logic [WIDTH_W-1:0] widths [NUM_CHANNELS];
  logic [WIDTH_W-1:0] old_width;

  // Current width of the channel being written
  always_comb begin
    old_width = '0;
    for (int j = 0; j < NUM_CHANNELS; j++) begin
      if (int'(wr.index) == j) begin
        old_width = widths[j];
      end
    end
  end

  // Widths and running high-span end bounds; a write shifts the written channel's bound and every later one
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        widths[k]   <= reset_width(k);
        hi_bound[k] <= reset_bound(k);
      end
    end else if (wr.en) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        if (int'(wr.index) == k) begin
          widths[k] <= wr.value;
        end
        if (k >= int'(wr.index)) begin
          hi_bound[k] <= hi_bound[k] - BOUND_W'(old_width) + BOUND_W'(wr.value);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/pfg_level_logic.sv */
`default_nettype none

module pfg_level_logic
  import pfg_pkg::*;
(
  input  wire logic [CNT_W-1:0] count,
  input  wire bound_vec_t       hi_bound,
  output logic                  level
);

  bound_t cnt_ext;
  bound_t gap;
  logic   done;

  assign cnt_ext = BOUND_W'(count);
  assign gap     = BOUND_W'(GAP_TICKS);

  // First span whose end reaches the count decides the level
  always_comb begin
    level = 1'b0;
    done  = 1'b0;
    if (cnt_ext <= gap) begin
      level = 1'b0;
      done  = 1'b1;
    end
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (!done) begin
        if (cnt_ext <= hi_bound[k]) begin
          level = 1'b1;
          done  = 1'b1;
        end else if (cnt_ext <= hi_bound[k] + gap) begin
          level = 1'b0;
          done  = 1'b1;
        end
      end
    end
    // past the last gap: high to end of frame
    if (!done) begin
      level = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/ppm_frame_generator.sv */
// Channel  Direction  Handshake            Fields
// in       sink       in_valid/in_stall    cmd, channel_index, channel_value
// out      source     out_valid/out_stall  ppm_level (one per tick, none per write)
//
// One item per cycle while in_stall is low; a held tick waits for room in the result register.
// Input register, compare against registered span bounds, result register.
// Writes update the bound bank as they leave the input register and are seen by the next item.
// Synchronous reset restores the counter and the default channel widths.
// in_stall rises only when a tick is held and the result register is stalled.
`default_nettype none

module ppm_frame_generator
  import pfg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [0:0]         cmd,
  input  wire logic [IDX_W-1:0]   channel_index,
  input  wire logic [WIDTH_W-1:0] channel_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    ppm_level
);

  logic               a_valid;
  cmd_t               a_cmd;
  logic [IDX_W-1:0]   a_index;
  logic [WIDTH_W-1:0] a_value;

  logic [CNT_W-1:0]   tick_count;
  logic [CNT_W-1:0]   count_inc;
  logic               a_advance;
  logic               tick_fire;
  logic               level;
  width_wr_t          wr;
  bound_vec_t         hi_bound;

  // Writes always drain; ticks need room in the result register
  assign a_advance = a_valid && (a_cmd == CMD_WRITE || !out_valid || !out_stall);
  assign in_stall  = a_valid && !a_advance;
  assign tick_fire = a_advance && (a_cmd == CMD_TICK);
  assign count_inc = tick_count + CNT_W'(1);

  assign wr.en    = a_advance && (a_cmd == CMD_WRITE)
                    && ({1'b0, a_index} < (IDX_W + 1)'(NUM_CHANNELS));
  assign wr.index = a_index;
  assign wr.value = a_value;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_cmd   <= cmd_t'(cmd);
      a_index <= channel_index;
      a_value <= channel_value;
    end
  end

  // Tick counter, wraps at end of frame
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (tick_fire) begin
      tick_count <= (count_inc >= CNT_W'(FRAME_TICKS)) ? '0 : count_inc;
    end
  end

  pfg_bound_bank u_bank (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .hi_bound (hi_bound)
  );

  pfg_level_logic u_level (
    .count    (count_inc),
    .hi_bound (hi_bound),
    .level    (level)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      ppm_level <= level;
    end
  end

endmodule

`default_nettype wire

/* rtl/pfg_port_checker.sv */
`default_nettype none

module pfg_port_checker
  import pfg_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [0:0]         cmd,
  input wire logic [IDX_W-1:0]   channel_index,
  input wire logic [WIDTH_W-1:0] channel_value,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               ppm_level
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its level
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(ppm_level))
    else $error("result level changed while stalled");

  // Input backpressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ppm_frame_generator pfg_port_checker u_port_checker (.*);

`default_nettype wire

/* tb/sv/ppm_frame_generator_test.sv */
`default_nettype none

module ppm_frame_generator_test;
  import pfg_pkg::*;

  localparam int RANDOM_ITEMS = 1530;
  localparam int CYCLE_LIMIT  = 120000;
  localparam int DRAIN_CYCLES = 12;

  // Tracks the frame counter and channel widths, and holds the line
  // levels still owed by the block in transfer order.
  class frame_level_board;
    logic [CNT_W-1:0]   tick_count;
    logic [WIDTH_W-1:0] widths [NUM_CHANNELS];
    logic               pending_levels [$];
    int                 errors;

    function new();
      tick_count = '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        widths[k] = (k == THROTTLE_SLOT) ? WIDTH_W'(RESET_THROTTLE) : WIDTH_W'(RESET_WIDTH);
      end
      errors = 0;
    endfunction

    // Walk the spans: leading gap, then high width and gap per channel,
    // then high to the end of the frame.
    function logic line_level_at(logic [CNT_W-1:0] c);
      bound_t bound;
      bound = bound_t'(GAP_TICKS);
      if (c <= bound) return 1'b0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        bound = bound + widths[k];
        if (c <= bound) return 1'b1;
        bound = bound + bound_t'(GAP_TICKS);
        if (c <= bound) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_transfer(cmd_t c, logic [IDX_W-1:0] idx, logic [WIDTH_W-1:0] val);
      logic [CNT_W-1:0] next_count;
      if (c == CMD_WRITE) begin
        // writes change a width only, no level comes back
        if (idx < NUM_CHANNELS) widths[idx] = val;
        return;
      end
      next_count = tick_count + 1'b1;
      pending_levels.push_back(line_level_at(next_count));
      tick_count = (next_count >= FRAME_TICKS) ? '0 : next_count;
    endfunction

    function void check_level(logic actual);
      logic want;
      if (pending_levels.size() == 0) begin
        errors++;
        $error("ppm_level: expected none, actual %0b", actual);
        return;
      end
      want = pending_levels.pop_front();
      if (actual !== want) begin
        errors++;
        $error("ppm_level: expected %0b, actual %0b", want, actual);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [0:0]         cmd = CMD_TICK;
  logic [IDX_W-1:0]   channel_index = '0;
  logic [WIDTH_W-1:0] channel_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               ppm_level;

  frame_level_board frame_board = new();
  int unsigned      cycle_count = 0;

  ppm_frame_generator uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ppm_level     (ppm_level)
  );

  // Clock and reset
  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ppm_frame_generator_test: errors");
      $finish;
    end
  end

  // Result side: check every transfer out
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      frame_board.check_level(ppm_level);
    end
  end

  // Result side stall: one long hold early while the sender keeps going,
  // then stretches of varying stall density, some with none at all.
  initial begin : receiver_stall
    int stretch;
    int style;
    @(negedge rst);
    repeat (8) @(posedge clk);
    out_stall <= 1'b1;
    repeat (120) @(posedge clk);
    forever begin
      stretch = $urandom_range(10, 150);
      style   = $urandom_range(0, 3);
      for (int i = 0; i < stretch; i++) begin
        case (style)
          0: begin
            out_stall <= 1'b0;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            out_stall <= ($urandom_range(0, 1) == 0);
          end
          default: begin
            out_stall <= ((i % 7) < 3);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until the transfer; valid stays high after.
  task automatic send_item(input cmd_t c, input logic [IDX_W-1:0] idx,
                           input logic [WIDTH_W-1:0] val);
    in_valid      <= 1'b1;
    cmd           <= c;
    channel_index <= idx;
    channel_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_board.note_transfer(c, idx, val);
  endtask

  task automatic idle_for(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++) begin
      send_item(CMD_TICK, IDX_W'($urandom_range(0, 7)), WIDTH_W'($urandom_range(0, 255)));
    end
  endtask

  // Input side
  initial begin : sender
    int                 burst_left;
    cmd_t               c;
    logic [IDX_W-1:0]   idx;
    logic [WIDTH_W-1:0] val;

    @(negedge rst);
    @(posedge clk);

    // Directed: leading gap, zero and full widths at the first and last
    // channel, a frame too long to fit, back to back into the long hold.
    send_ticks(2);
    send_item(CMD_WRITE, IDX_W'(0), WIDTH_W'(0));
    send_item(CMD_WRITE, IDX_W'(7), WIDTH_W'(255));
    send_item(CMD_WRITE, IDX_W'(1), WIDTH_W'(255));
    send_item(CMD_WRITE, IDX_W'(6), WIDTH_W'(0));
    send_ticks(4);
    send_item(CMD_WRITE, IDX_W'(2), WIDTH_W'(128));
    send_item(CMD_WRITE, IDX_W'(3), WIDTH_W'(1));
    send_item(CMD_WRITE, IDX_W'(4), WIDTH_W'(127));
    send_item(CMD_WRITE, IDX_W'(5), WIDTH_W'(254));
    send_ticks(8);

    // Random: mostly ticks so frames run through and wrap, with width
    // writes mixed in, biased toward zero and full width.
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 8));
      end
      burst_left--;
      idx = IDX_W'($urandom_range(0, 7));
      val = WIDTH_W'($urandom_range(0, 255));
      c   = CMD_TICK;
      if ($urandom_range(0, 9) == 0) begin
        c = CMD_WRITE;
        case ($urandom_range(0, 3))
          0: val = '0;
          1: val = '1;
          default: ;
        endcase
      end
      send_item(c, idx, val);
    end

    // Drain
    in_valid <= 1'b0;
    while (frame_board.pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_board.errors == 0) begin
      $display("ppm_frame_generator_test: clean");
    end else begin
      $display("ppm_frame_generator_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
